// File: hw/rtl/ubx_nfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX/NMEA frame splitter package
// Parse phases, framing byte codes and the result beat type.
// ----------------------------------------------------------------------------
package ubx_nfs_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEFT_W = 17;

   localparam logic [BYTE_W-1:0] NMEA_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] NMEA_BANG   = 8'h21;
   localparam logic [BYTE_W-1:0] NMEA_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] NMEA_CTRL   = 8'h20;
   localparam logic [BYTE_W-1:0] UBX_SYNC1   = 8'hB5;

   localparam logic KIND_NMEA = 1'b0;
   localparam logic KIND_UBX  = 1'b1;

   localparam logic [LEFT_W-1:0] HEAD_SYNC2  = 17'd4;
   localparam logic [LEFT_W-1:0] HEAD_LENLO  = 17'd1;
   localparam logic [LEFT_W-1:0] LEFT_CK_A   = 17'd2;
   localparam logic [LEFT_W-1:0] LEFT_CK_B   = 17'd1;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_NMEA_BODY = 3'd1,
      PH_NMEA_CK1  = 3'd2,
      PH_NMEA_CK2  = 3'd3,
      PH_UBX_HEAD  = 3'd4,
      PH_UBX_LENHI = 3'd5,
      PH_UBX_BODY  = 3'd6
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              frame_kind;
      logic              frame_first;
      logic              frame_last;
      logic              checksum_good;
   } rsp_item_type;

endpackage

// File: hw/rtl/ubx_nfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX/NMEA frame splitter channels
// Valid/ready byte channel in and frame beat channel out.
// ----------------------------------------------------------------------------
interface ubx_nfs_req_if;
   logic                           valid;
   logic                           ready;
   logic [ubx_nfs_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ubx_nfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ubx_nfs_pkg::BYTE_W-1:0] out_byte;
   logic                           frame_kind;
   logic                           frame_first;
   logic                           frame_last;
   logic                           checksum_good;

   modport source (output valid, output out_byte, output frame_kind,
                   output frame_first, output frame_last, output checksum_good,
                   input ready);
   modport sink   (input valid, input out_byte, input frame_kind,
                   input frame_first, input frame_last, input checksum_good,
                   output ready);
endinterface

// File: hw/rtl/ubx_nmea_frame_splitter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX/NMEA frame splitter core
// Path: an accepted byte passes the input register, the parse logic and the result register before it
// shows on the result channel. Throughput: one byte per cycle while the result channel is not stalled,
// set by the single parse stage between the input register and the result register.
// Reset: synchronous; parser returns to hunting, both registers empty.
// ----------------------------------------------------------------------------
module ubx_nmea_frame_splitter_core (
   input  logic           clock,
   input  logic           reset,
   ubx_nfs_req_if.sink    req_chan,
   ubx_nfs_rsp_if.source  rsp_chan
);

   logic                                   in_valid_ff;
   logic [ubx_nfs_pkg::BYTE_W-1:0]         in_byte_ff;
   logic                                   out_valid_ff;
   ubx_nfs_pkg::rsp_item_type              out_item_ff;

   ubx_nfs_pkg::phase_type                 phase_ff, phase_in;
   logic [ubx_nfs_pkg::LEFT_W-1:0]         left_ff, left_in;
   logic [ubx_nfs_pkg::BYTE_W-1:0]         len_lo_ff, len_lo_in;
   logic [ubx_nfs_pkg::BYTE_W-1:0]         sum_a_ff, sum_a_in;
   logic [ubx_nfs_pkg::BYTE_W-1:0]         sum_b_ff, sum_b_in;
   logic                                   ck_a_ok_ff, ck_a_ok_in;

   logic [ubx_nfs_pkg::BYTE_W-1:0]         add_a;
   logic [ubx_nfs_pkg::BYTE_W-1:0]         add_b;
   logic                                   emit;
   ubx_nfs_pkg::rsp_item_type              res;
   logic                                   out_load;
   logic                                   parse_go;

   assign out_load       = !out_valid_ff || rsp_chan.ready;
   assign parse_go       = in_valid_ff && out_load;
   assign req_chan.ready = !in_valid_ff || out_load;

   assign add_a = sum_a_ff + in_byte_ff;
   assign add_b = sum_b_ff + add_a;

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      len_lo_in  = len_lo_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      ck_a_ok_in = ck_a_ok_ff;
      emit       = 1'b0;
      res        = '{out_byte:      in_byte_ff,
                     frame_kind:    ubx_nfs_pkg::KIND_NMEA,
                     frame_first:   1'b0,
                     frame_last:    1'b0,
                     checksum_good: 1'b0};
      unique case (phase_ff)
         ubx_nfs_pkg::PH_IDLE: begin
            if (in_byte_ff == ubx_nfs_pkg::NMEA_DOLLAR ||
                in_byte_ff == ubx_nfs_pkg::NMEA_BANG) begin
               phase_in        = ubx_nfs_pkg::PH_NMEA_BODY;
               emit            = 1'b1;
               res.frame_first = 1'b1;
            end else if (in_byte_ff == ubx_nfs_pkg::UBX_SYNC1) begin
               phase_in        = ubx_nfs_pkg::PH_UBX_HEAD;
               left_in         = ubx_nfs_pkg::HEAD_SYNC2;
               sum_a_in        = '0;
               sum_b_in        = '0;
               ck_a_ok_in      = 1'b0;
               emit            = 1'b1;
               res.frame_kind  = ubx_nfs_pkg::KIND_UBX;
               res.frame_first = 1'b1;
            end
         end
         ubx_nfs_pkg::PH_NMEA_BODY: begin
            if (in_byte_ff < ubx_nfs_pkg::NMEA_CTRL) begin
               phase_in = ubx_nfs_pkg::PH_NMEA_CK1;
            end else begin
               emit = 1'b1;
               if (in_byte_ff == ubx_nfs_pkg::NMEA_STAR) begin
                  phase_in = ubx_nfs_pkg::PH_NMEA_CK1;
               end
            end
         end
         ubx_nfs_pkg::PH_NMEA_CK1: begin
            phase_in = ubx_nfs_pkg::PH_NMEA_CK2;
            emit     = 1'b1;
         end
         ubx_nfs_pkg::PH_NMEA_CK2: begin
            phase_in       = ubx_nfs_pkg::PH_IDLE;
            emit           = 1'b1;
            res.frame_last = 1'b1;
         end
         ubx_nfs_pkg::PH_UBX_HEAD: begin
            emit           = 1'b1;
            res.frame_kind = ubx_nfs_pkg::KIND_UBX;
            if (left_ff != ubx_nfs_pkg::HEAD_SYNC2) begin
               sum_a_in = add_a;
               sum_b_in = add_b;
            end
            if (left_ff <= ubx_nfs_pkg::HEAD_LENLO) begin
               len_lo_in = in_byte_ff;
               phase_in  = ubx_nfs_pkg::PH_UBX_LENHI;
               left_in   = '0;
            end else begin
               left_in = left_ff - 1'b1;
            end
         end
         ubx_nfs_pkg::PH_UBX_LENHI: begin
            emit           = 1'b1;
            res.frame_kind = ubx_nfs_pkg::KIND_UBX;
            sum_a_in       = add_a;
            sum_b_in       = add_b;
            left_in        = {1'b0, in_byte_ff, len_lo_ff} + ubx_nfs_pkg::LEFT_CK_A;
            phase_in       = ubx_nfs_pkg::PH_UBX_BODY;
         end
         ubx_nfs_pkg::PH_UBX_BODY: begin
            emit           = 1'b1;
            res.frame_kind = ubx_nfs_pkg::KIND_UBX;
            priority if (left_ff > ubx_nfs_pkg::LEFT_CK_A) begin
               sum_a_in = add_a;
               sum_b_in = add_b;
               left_in  = left_ff - 1'b1;
            end else if (left_ff == ubx_nfs_pkg::LEFT_CK_A) begin
               ck_a_ok_in = (in_byte_ff == sum_a_ff);
               left_in    = ubx_nfs_pkg::LEFT_CK_B;
            end else begin
               res.frame_last    = 1'b1;
               res.checksum_good = ck_a_ok_ff && (in_byte_ff == sum_b_ff);
               phase_in          = ubx_nfs_pkg::PH_IDLE;
               left_in           = '0;
            end
         end
         default: begin
            phase_in = ubx_nfs_pkg::PH_IDLE;
            left_in  = '0;
         end
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
      end
   end

   // parser state: advance only when the byte leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ubx_nfs_pkg::PH_IDLE;
         left_ff    <= '0;
         len_lo_ff  <= '0;
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         ck_a_ok_ff <= 1'b0;
      end else if (parse_go) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         len_lo_ff  <= len_lo_in;
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         ck_a_ok_ff <= ck_a_ok_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= parse_go && emit;
      end
      if (out_load) begin
         out_item_ff <= res;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.out_byte      = out_item_ff.out_byte;
   assign rsp_chan.frame_kind    = out_item_ff.frame_kind;
   assign rsp_chan.frame_first   = out_item_ff.frame_first;
   assign rsp_chan.frame_last    = out_item_ff.frame_last;
   assign rsp_chan.checksum_good = out_item_ff.checksum_good;

endmodule

// File: hw/rtl/ubx_nfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX/NMEA frame splitter checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module ubx_nfs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ubx_nfs_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                           rsp_frame_kind,
   input logic                           rsp_frame_first,
   input logic                           rsp_frame_last,
   input logic                           rsp_checksum_good
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_frame_kind) && $stable(rsp_frame_last))
      else $error("result beat changed while stalled");

   a_good_on_ubx_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_good |->
      rsp_frame_last && rsp_frame_kind == ubx_nfs_pkg::KIND_UBX)
      else $error("checksum flag outside final UBX beat");

   a_first_is_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_first |->
      (rsp_frame_kind == ubx_nfs_pkg::KIND_UBX && rsp_out_byte == ubx_nfs_pkg::UBX_SYNC1) ||
      (rsp_frame_kind == ubx_nfs_pkg::KIND_NMEA &&
       (rsp_out_byte == ubx_nfs_pkg::NMEA_DOLLAR || rsp_out_byte == ubx_nfs_pkg::NMEA_BANG)))
      else $error("first beat is not a start byte");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind ubx_nmea_frame_splitter_core ubx_nfs_checker u_ubx_nfs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_byte      (rsp_chan.out_byte),
   .rsp_frame_kind    (rsp_chan.frame_kind),
   .rsp_frame_first   (rsp_chan.frame_first),
   .rsp_frame_last    (rsp_chan.frame_last),
   .rsp_checksum_good (rsp_chan.checksum_good)
);
